@@ hdl/first_unique_symbol_tracker_core_defines.svh @@
`ifndef FIRST_UNIQUE_SYMBOL_TRACKER_CORE_DEFINES_SVH
`define FIRST_UNIQUE_SYMBOL_TRACKER_CORE_DEFINES_SVH

// same-cycle and next-cycle implication checks on clk, disabled in reset
`ifndef NO_ASSERTIONS
`define FUST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fust check failed");
`define FUST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fust check failed");
`else
`define FUST_ASSERT_IMP(lbl, ante, cons)
`define FUST_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hdl/fust_pkg.sv @@
package fust_pkg;

    localparam int NUM_SYMBOLS = 256;
    localparam int SYM_W       = 8;
    localparam int NUM_CELLS   = (NUM_SYMBOLS < (1 << SYM_W)) ? NUM_SYMBOLS : (1 << SYM_W);
    localparam int IDX_W       = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             start_stream;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [SYM_W-1:0] first_unique;
    } result_t;

    typedef struct packed {
        logic             clear;
        logic             push;
        logic             match_en;
        logic             find;
        logic             shift;
        logic [SYM_W-1:0] sym;
    } cell_ctrl_t;

endpackage

@@ hdl/fust_cell.sv @@
module fust_cell
    import fust_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic             left_valid,
    input  logic             right_valid,
    input  logic [SYM_W-1:0] right_sym,
    input  logic             shift_en,
    output logic             valid,
    output logic [SYM_W-1:0] sym,
    output logic             match
);

    logic             valid_reg;
    logic             valid_next;
    logic             match_reg;
    logic             match_next;
    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] sym_next;

    always_comb
    begin
        valid_next = valid_reg;
        sym_next   = sym_reg;
        match_next = match_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        // append into the first free cell
        if (ctrl.push && !valid_reg && left_valid)
        begin
            valid_next = 1'b1;
            sym_next   = ctrl.sym;
        end
        if (ctrl.match_en)
        begin
            match_next = valid_reg && (sym_reg == ctrl.sym);
        end
        // close the gap left by the removed symbol
        if (ctrl.shift && shift_en)
        begin
            valid_next = right_valid;
            sym_next   = right_sym;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
    end

    assign valid = valid_reg;
    assign sym   = sym_reg;
    assign match = match_reg;

endmodule

@@ hdl/fust_cell_row.sv @@
module fust_cell_row
    import fust_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    output logic             head_valid,
    output logic [SYM_W-1:0] head_sym
);

    logic             valid_w [NUM_CELLS];
    logic [SYM_W-1:0] sym_w   [NUM_CELLS];
    logic             match_w [NUM_CELLS];
    logic             left_w  [NUM_CELLS];
    logic             rvalid_w[NUM_CELLS];
    logic [SYM_W-1:0] rsym_w  [NUM_CELLS];
    logic             shen_w  [NUM_CELLS];
    logic [IDX_W-1:0] idx_enc;
    logic [IDX_W-1:0] rm_idx_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left_w[gi] = 1'b1;
            end
            else
            begin : g_rest
                assign left_w[gi] = valid_w[gi-1];
            end

            if (gi == NUM_CELLS - 1)
            begin : g_last
                assign rvalid_w[gi] = 1'b0;
                assign rsym_w[gi]   = '0;
            end
            else
            begin : g_inner
                assign rvalid_w[gi] = valid_w[gi+1];
                assign rsym_w[gi]   = sym_w[gi+1];
            end

            assign shen_w[gi] = (IDX_W'(gi) >= rm_idx_reg);

            fust_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_valid  (left_w[gi]),
                .right_valid (rvalid_w[gi]),
                .right_sym   (rsym_w[gi]),
                .shift_en    (shen_w[gi]),
                .valid       (valid_w[gi]),
                .sym         (sym_w[gi]),
                .match       (match_w[gi])
            );
        end
    endgenerate

    // match is one-hot, so an or of the indexes gives the position
    always_comb
    begin
        idx_enc = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (match_w[i])
            begin
                idx_enc = idx_enc | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.find)
        begin
            rm_idx_reg <= idx_enc;
        end
    end

    assign head_valid = valid_w[0];
    assign head_sym   = sym_w[0];

endmodule

@@ hdl/first_unique_symbol_tracker_core.sv @@
// channel | handshake                  | payload
// item    | item_valid / item_stall    | item   (symbol, start_stream)
// result  | result_valid / result_stall | result (found, first_unique)
//
// one item at a time: a symbol already repeated goes straight to done, a first
// sighting is pushed, a second goes through match, locate, shift in the cell row
// the row of cells holds the list in arrival order, head in the first cell
// rst_n clears marks, cell valids and state at once, no clearing pass
// result register frees the core: a stalled result only holds the next item's
// finish, item_stall is high while an item is in work

`include "first_unique_symbol_tracker_core_defines.svh"

module first_unique_symbol_tracker_core
    import fust_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PUSH  = 6'b000010,
        ST_MATCH = 6'b000100,
        ST_FIND  = 6'b001000,
        ST_SHIFT = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [NUM_CELLS-1:0] in_list_reg;
    logic [NUM_CELLS-1:0] in_list_next;
    logic [NUM_CELLS-1:0] rep_reg;
    logic [NUM_CELLS-1:0] rep_next;
    logic [SYM_W-1:0]     sym_reg;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    result_t              result_reg;
    logic                 accept;
    logic                 sym_ok;
    logic [IDX_W-1:0]     sym_idx;
    logic                 cur_in;
    logic                 cur_rep;
    logic                 do_push;
    logic                 do_rm;
    logic                 load_result;
    cell_ctrl_t           ctrl;
    logic                 head_valid;
    logic [SYM_W-1:0]     head_sym;

    assign accept  = item_valid && !item_stall;
    assign sym_ok  = (int'(item.symbol) < NUM_SYMBOLS);
    assign sym_idx = item.symbol[IDX_W-1:0];
    assign cur_in  = item.start_stream ? 1'b0 : in_list_reg[sym_idx];
    assign cur_rep = item.start_stream ? 1'b0 : rep_reg[sym_idx];
    assign do_push = sym_ok && !cur_rep && !cur_in;
    assign do_rm   = sym_ok && !cur_rep && cur_in;

    assign item_stall  = (state_reg != ST_IDLE);
    assign load_result = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        in_list_next = in_list_reg;
        rep_next     = rep_reg;
        if (accept)
        begin
            if (item.start_stream)
            begin
                in_list_next = '0;
                rep_next     = '0;
            end
            if (do_push)
            begin
                in_list_next[sym_idx] = 1'b1;
            end
            if (do_rm)
            begin
                in_list_next[sym_idx] = 1'b0;
                rep_next[sym_idx]     = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (do_push)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if (do_rm)
                    begin
                        state_next = ST_MATCH;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PUSH:  state_next = ST_DONE;
            ST_MATCH: state_next = ST_FIND;
            ST_FIND:  state_next = ST_SHIFT;
            ST_SHIFT: state_next = ST_DONE;
            ST_DONE:
            begin
                if (load_result)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.clear    = accept && item.start_stream;
        ctrl.push     = (state_reg == ST_PUSH);
        ctrl.match_en = (state_reg == ST_MATCH);
        ctrl.find     = (state_reg == ST_FIND);
        ctrl.shift    = (state_reg == ST_SHIFT);
        ctrl.sym      = sym_reg;
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        if (load_result)
        begin
            result_valid_next = 1'b1;
        end
    end

    fust_cell_row u_row (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .head_valid (head_valid),
        .head_sym   (head_sym)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            in_list_reg      <= '0;
            rep_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            in_list_reg      <= in_list_next;
            rep_reg          <= rep_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg <= item.symbol;
        end
        if (load_result)
        begin
            result_reg.found        <= head_valid;
            result_reg.first_unique <= head_valid ? head_sym : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `FUST_ASSERT_NXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE)
    `FUST_ASSERT_NXT(a_match_then_find, state_reg == ST_MATCH, state_reg == ST_FIND)
    `FUST_ASSERT_IMP(a_marks_exclusive, 1'b1, (in_list_reg & rep_reg) == '0)
    `FUST_ASSERT_IMP(a_head_tracks_marks, state_reg == ST_IDLE, (|in_list_reg) == head_valid)
    `FUST_ASSERT_IMP(a_empty_result_zero, result_valid_reg && !result_reg.found,
                     result_reg.first_unique == '0)

endmodule
